>>> src/sitoa_pkg.sv
// ============================================================================
// sitoa_pkg - shared types and constants for the signed integer to text block
// Field widths, radix limits, the digit character table and the control and
// status bundles between the sequencer and the serial divider.
// ============================================================================
`default_nettype none

package sitoa_pkg;

    localparam int VALUE_BITS          = 64;  // width of the value field on the port
    localparam int VALUE_WIDTH_DEFAULT = 64;
    localparam int RADIX_BITS          = 5;
    localparam int DIGIT_BITS          = 4;
    localparam int CH_BITS             = 7;
    localparam int OUT_TDATA_BITS      = 8;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;

    // lower-case ascii digits, indexed by digit value
    localparam logic [CH_BITS-1:0] DIGIT_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef struct packed {
        logic load;   // load a new dividend and begin a pass
        logic start;  // begin a pass on the quotient left by the last one
    } div_ctrl_t;

    typedef struct packed {
        logic                  done;   // one-cycle pulse at the end of a pass
        logic [DIGIT_BITS-1:0] digit;  // remainder of the last pass
        logic                  q_nz;   // quotient of the last pass is non-zero
    } div_stat_t;

endpackage

`default_nettype wire

>>> src/sitoa_ram.sv
// ============================================================================
// sitoa_ram - generic simple dual-port ram
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module sitoa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/sitoa_div.sv
// ============================================================================
// sitoa_div - bit-serial divider by a small radix
// Restoring division, one dividend bit per cycle; the quotient shifts back
// into the dividend register so the next pass divides it again.
// ============================================================================
`default_nettype none

module sitoa_div #(
    parameter int W = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sitoa_pkg::div_ctrl_t               ctrl,
    input  wire logic [W-1:0]                       dividend,
    input  wire logic [sitoa_pkg::RADIX_BITS-1:0]   radix,
    output sitoa_pkg::div_stat_t                    stat
);

    import sitoa_pkg::*;

    localparam int SW = (W > 1) ? $clog2(W) : 1;
    localparam logic [SW-1:0] LAST_STEP = SW'(W - 1);

    logic [W-1:0]            q_reg, q_next;
    logic [DIGIT_BITS-1:0]   rem_reg, rem_next;
    logic [SW-1:0]           step_reg, step_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    qnz_reg, qnz_next;

    logic [RADIX_BITS-1:0]   trial;
    logic [RADIX_BITS-1:0]   diff;
    logic                    q_bit;

    always_comb
    begin
        trial = {rem_reg, q_reg[W-1]};
        diff  = trial - radix;
        q_bit = (trial >= radix);
    end

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        qnz_next  = qnz_reg;
        if (ctrl.load || ctrl.start)
        begin
            if (ctrl.load)
            begin
                q_next = dividend;
            end
            rem_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
            qnz_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            q_next    = {q_reg[W-2:0], q_bit};
            rem_next  = q_bit ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
            qnz_next  = qnz_reg | q_bit;
            step_next = step_reg + SW'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            qnz_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            qnz_reg  <= qnz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign stat.done  = done_reg;
    assign stat.digit = rem_reg;
    assign stat.q_nz  = qnz_reg;

endmodule

`default_nettype wire

>>> src/signed_int_to_ascii_base.sv
// ============================================================================
// signed_int_to_ascii_base - signed integer to ascii text in base 2 to 16
// Takes the magnitude of each value, splits it into digits with a serial
// divider, stores them and sends them back most significant first.
// ============================================================================
//
//  channel   dir  fields                                 per transfer
//  s_axis    in   tdata[63:0] value                      one integer
//  m_axis    out  tdata[6:0] ch, tuser negative, tlast   one digit
//  cfg       in   cfg_wdata[4:0] radix                   one register write
//
//  each digit comes from one pass of the bit-serial divider, and each digit sent
//  goes through the digit ram and output register in the ST_RD, ST_LOAD and
//  ST_SEND states.
//  no input is taken until the last digit of the previous item is sent.
//  reset leaves radix at ten and the block idle; the digit ram is not cleared.
//  a stall on m_axis holds the current digit and the whole item behind it.
//
`default_nettype none

module signed_int_to_ascii_base #(
    parameter int VALUE_WIDTH = sitoa_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,

    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [sitoa_pkg::VALUE_BITS-1:0]       s_axis_tdata,   // [63:0] value

    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [sitoa_pkg::OUT_TDATA_BITS-1:0]        m_axis_tdata,   // [6:0] ch, [7] zero
    output logic                                        m_axis_tuser,   // [0] negative
    output logic                                        m_axis_tlast,

    input  wire logic                                   cfg_we,
    input  wire logic [sitoa_pkg::RADIX_BITS-1:0]       cfg_wdata
);

    import sitoa_pkg::*;

    localparam int AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam logic [CW-1:0] MAX_DIGITS = CW'(VALUE_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    neg_reg, neg_next;
    logic [CH_BITS-1:0]      ch_reg, ch_next;
    logic                    last_reg, last_next;
    logic                    valid_reg, valid_next;
    logic [RADIX_BITS-1:0]   radix_reg;

    logic [RADIX_BITS-1:0]   radix_eff;
    logic [VALUE_WIDTH-1:0]  v;
    logic [VALUE_WIDTH-1:0]  mag;
    logic [CW-1:0]           cnt_inc;
    logic [CW-1:0]           cnt_dec;
    logic                    in_xfer;

    div_ctrl_t               div_ctrl;
    div_stat_t               div_stat;

    logic                    ram_we;
    logic [DIGIT_BITS-1:0]   ram_rdata;

    always_comb
    begin
        if (radix_reg < RADIX_MIN)
        begin
            radix_eff = RADIX_MIN;
        end
        else if (radix_reg > RADIX_MAX)
        begin
            radix_eff = RADIX_MAX;
        end
        else
        begin
            radix_eff = radix_reg;
        end
    end

    // magnitude taken as unsigned so the most negative value works too
    assign v       = s_axis_tdata[VALUE_WIDTH-1:0];
    assign mag     = v[VALUE_WIDTH-1] ? VALUE_WIDTH'(~v + 1'b1) : v;
    assign cnt_inc = cnt_reg + CW'(1);
    assign cnt_dec = cnt_reg - CW'(1);
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    sitoa_div #(
        .W (VALUE_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (mag),
        .radix    (radix_eff),
        .stat     (div_stat)
    );

    // digits land least significant first at the running count
    sitoa_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (VALUE_WIDTH)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (div_stat.digit),
        .raddr (cnt_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        ch_next        = ch_reg;
        last_next      = last_reg;
        valid_next     = valid_reg;
        div_ctrl.load  = 1'b0;
        div_ctrl.start = 1'b0;
        ram_we         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next      = v[VALUE_WIDTH-1];
                    cnt_next      = '0;
                    div_ctrl.load = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    ram_we   = 1'b1;
                    cnt_next = cnt_inc;
                    if (!div_stat.q_nz || cnt_inc == MAX_DIGITS)
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                ch_next    = DIGIT_CHARS[ram_rdata];
                last_next  = (cnt_reg == CW'(1));
                cnt_next   = cnt_dec;
                valid_next = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (m_axis_tready)
                begin
                    valid_next = 1'b0;
                    state_next = last_reg ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            radix_reg <= RADIX_RESET;
            neg_reg   <= 1'b0;
            ch_reg    <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            neg_reg   <= neg_next;
            ch_reg    <= ch_next;
            last_reg  <= last_next;
            if (cfg_we)
            begin
                radix_reg <= cfg_wdata;
            end
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {1'b0, ch_reg};
    assign m_axis_tuser  = neg_reg;
    assign m_axis_tlast  = last_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a digit is pending");

    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not idle after last digit");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> ({1'b0, div_stat.digit} < radix_eff))
        else $error("digit not below radix");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside division");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_DIGITS)
        else $error("digit count past value width");

endmodule

`default_nettype wire

>>> bench/signed_int_to_ascii_base_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// signed_int_to_ascii_base_tb - self-checking bench for the integer to text block
// Streams signed 64-bit values in, predicts the digit string of each in the
// current radix and checks every digit transfer on the output stream, over
// several radix settings including the saturating ones, with random idling
// and back-pressure on both sides.
// ============================================================================

module signed_int_to_ascii_base_tb;

    typedef struct packed {
        logic [6:0] ch;
        logic       negative;
        logic       last;
    } digit_t;

    class digit_scoreboard;
        logic [4:0] radix;
        digit_t     pending_digits[$];
        int         values_seen;
        int         digits_checked;
        int         negative_digits;
        int         errors;

        function new();
            radix           = 5'd10;
            values_seen     = 0;
            digits_checked  = 0;
            negative_digits = 0;
            errors          = 0;
        endfunction

        function int pending();
            return pending_digits.size();
        endfunction

        // expands one accepted value into its digit transfers, most significant first
        function void note_value(logic [63:0] value);
            logic [63:0] mag;
            logic [63:0] base;
            logic        neg;
            logic [3:0]  digs[64];
            int          n;
            digit_t      d;

            neg  = value[63];
            mag  = neg ? (~value + 64'd1) : value;
            base = (radix < 5'd2) ? 64'd2 : (radix > 5'd16) ? 64'd16 : {59'd0, radix};
            n    = 0;
            do
            begin
                digs[n] = 4'(mag % base);
                mag     = mag / base;
                n++;
            end
            while (mag != 64'd0 && n < 64);
            for (int k = n - 1; k >= 0; k--)
            begin
                d.ch       = (digs[k] < 4'd10) ? (7'h30 + digs[k]) : (7'h57 + digs[k]);
                d.negative = neg;
                d.last     = (k == 0);
                pending_digits.push_back(d);
            end
            values_seen++;
        endfunction

        function void check_result(logic [7:0] tdata, logic tuser, logic tlast);
            digit_t exp_d;

            if (pending_digits.size() == 0)
            begin
                $error("unexpected digit transfer: tdata %h tuser %b tlast %b",
                       tdata, tuser, tlast);
                errors++;
                return;
            end
            exp_d = pending_digits.pop_front();
            digits_checked++;
            if (exp_d.negative)
                negative_digits++;
            if (tdata !== {1'b0, exp_d.ch})
            begin
                $error("ch mismatch: expected %h, actual %h", {1'b0, exp_d.ch}, tdata);
                errors++;
            end
            if (tuser !== exp_d.negative)
            begin
                $error("negative mismatch: expected %b, actual %b", exp_d.negative, tuser);
                errors++;
            end
            if (tlast !== exp_d.last)
            begin
                $error("last mismatch: expected %b, actual %b", exp_d.last, tlast);
                errors++;
            end
        endfunction
    endclass

    logic                                    clk;
    logic                                    rst_n;
    logic                                    s_axis_tvalid;
    logic                                    s_axis_tready;
    logic [sitoa_pkg::VALUE_BITS-1:0]        s_axis_tdata;      // [63:0] value
    logic                                    m_axis_tvalid;
    logic                                    m_axis_tready;
    logic [sitoa_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata;      // [6:0] ch, [7] zero
    logic                                    m_axis_tuser;      // [0] negative
    logic                                    m_axis_tlast;
    logic                                    cfg_we;
    logic [sitoa_pkg::RADIX_BITS-1:0]        cfg_wdata;

    digit_scoreboard digits_sb;
    logic            idle_on;
    logic            hold_req;
    int              radix_writes;

    signed_int_to_ascii_base dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiving side: random stalls, plus one long hold-off on request
    initial
    begin
        int gap;

        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready = 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 5);
                m_axis_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            digits_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    task automatic send_value(input logic [63:0] value);
        int gap;

        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        digits_sb.note_value(value);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (digits_sb.pending() != 0)
            @(posedge clk);
    endtask

    // radix changes only once the block has sent every digit it owes
    task automatic write_radix(input logic [4:0] r);
        stop_sending();
        drain();
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = r;
        @(negedge clk);
        cfg_we    = 1'b0;
        digits_sb.radix = r;
        radix_writes++;
    endtask

    // mostly short magnitudes to keep base-two runs cheap, some full-width
    function automatic logic [63:0] make_value();
        logic [63:0] raw;
        int          sel;
        int          len;

        sel = $urandom_range(0, 9);
        raw = {$urandom, $urandom};
        if (sel < 2)
            return raw;
        if (sel == 2)
        begin
            case ($urandom_range(0, 4))
                0: return 64'd0;
                1: return 64'h8000_0000_0000_0000;
                2: return 64'h7fff_ffff_ffff_ffff;
                3: return 64'hffff_ffff_ffff_ffff;
                default: return 64'd1;
            endcase
        end
        len = $urandom_range(1, 20);
        raw = raw & ((64'd1 << len) - 64'd1);
        if ($urandom_range(0, 1) == 1)
            raw = -raw;
        return raw;
    endfunction

    initial
    begin
        logic [4:0] phase_radix[8];

        phase_radix = '{5'd10, 5'd2, 5'd16, 5'd7, 5'd3, 5'd31, 5'd1, 5'd10};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        radix_writes  = 0;
        digits_sb     = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset radix of ten
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'hffff_ffff_ffff_ffff);
        send_value(64'h7fff_ffff_ffff_ffff);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'd9);
        send_value(-64'sd10);
        write_radix(5'd2);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h7fff_ffff_ffff_ffff);
        send_value(64'hffff_ffff_ffff_ffff);
        send_value(64'd0);
        write_radix(5'd16);
        send_value(64'hfedc_ba98_7654_3210);
        send_value(64'h0123_4567_89ab_cdef);
        send_value(64'h8000_0000_0000_0000);
        // radix below two saturates to two
        write_radix(5'd0);
        send_value(64'd5);
        send_value(-64'sd6);
        write_radix(5'd1);
        send_value(64'd3);
        // radix above sixteen saturates to sixteen
        write_radix(5'd17);
        send_value(64'd255);
        write_radix(5'd31);
        send_value(-64'sd256);
        write_radix(5'd3);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'd0);

        for (int p = 0; p < 8; p++)
        begin
            write_radix((p == 3) ? 5'($urandom_range(2, 16)) : phase_radix[p]);
            idle_on = (p < 7);
            for (int i = 0; i < 60; i++)
            begin
                // long receiver hold-off while the sender keeps offering transfers
                if (p == 2 && i == 10)
                    hold_req = 1'b1;
                if (p == 4 && i == 30)
                begin
                    stop_sending();
                    drain();
                end
                send_value(make_value());
            end
        end

        stop_sending();
        drain();
        repeat (300) @(posedge clk);

        $display("converted %0d values into %0d digit transfers (%0d from negative values)",
                 digits_sb.values_seen, digits_sb.digits_checked, digits_sb.negative_digits);
        $display("%0d radix writes, saturating settings and a long output stall included",
                 radix_writes);
        if (digits_sb.errors == 0 && digits_sb.pending() == 0)
            $display("RESULT: OK");
        else
        begin
            if (digits_sb.pending() != 0)
                $error("%0d expected digits never arrived", digits_sb.pending());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
src/sitoa_pkg.sv
src/sitoa_ram.sv
src/sitoa_div.sv
src/signed_int_to_ascii_base.sv
bench/signed_int_to_ascii_base_tb.sv
